### hdl/varenc_pkg.sv
// Shared constants and types for the unsigned varint encoder.
package varenc_pkg;

  localparam int ValueW  = 64;
  localparam int DigitW  = 7;
  localparam int ByteW   = 8;
  localparam int CountW  = 4;
  localparam int MaxBytes = 9;

  // Byte count just before the ninth, full eight-bit byte is emitted.
  localparam logic [CountW-1:0] LastGroupCount = CountW'(MaxBytes - 1);

  // Encoded digit as it moves from the shifter to the output register.
  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic [CountW-1:0] byte_count;
    logic              last_byte;
  } digit_t;

  // Control from the top level to the shifter.
  typedef struct packed {
    logic load;
    logic step;
  } shift_ctrl_t;

endpackage

### hdl/varenc_shift.sv
// Digit shifter: holds the value bits not yet sent and forms one byte per step.
module varenc_shift (
  input  logic                          clk,
  input  logic                          rst,
  input  varenc_pkg::shift_ctrl_t       ctrl,
  input  logic [varenc_pkg::ValueW-1:0] value,
  output logic                          busy,
  output varenc_pkg::digit_t            digit
);
  import varenc_pkg::*;

  logic [ValueW-1:0] remaining;
  logic [CountW-1:0] emitted;
  logic              ninth;
  logic              more;

  // Form the next byte from the low end of the remaining bits.
  always_comb begin
    ninth = (emitted == LastGroupCount);
    more  = !ninth && (remaining[ValueW-1:DigitW] != '0);
    digit.byte_count = emitted + CountW'(1);
    digit.last_byte  = !more;
    if (ninth) begin
      digit.out_byte = remaining[ByteW-1:0];
    end else begin
      digit.out_byte = {more, remaining[DigitW-1:0]};
    end
  end

  // A new word loads the shifter; each step drops one seven-bit group.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      emitted <= '0;
    end else if (ctrl.load) begin
      busy    <= 1'b1;
      emitted <= '0;
    end else if (ctrl.step) begin
      busy    <= more;
      emitted <= emitted + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      remaining <= value;
    end else if (ctrl.step) begin
      remaining <= remaining >> DigitW;
    end
  end

endmodule

### hdl/varenc_obuf.sv
// Output register: holds one encoded word until the consumer takes it.
module varenc_obuf (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  varenc_pkg::digit_t              digit,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [varenc_pkg::ByteW-1:0]    out_byte,
  output logic [varenc_pkg::CountW-1:0]   byte_count,
  output logic                            last_byte
);
  import varenc_pkg::*;

  // Valid flag follows fills and takes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload is captured whenever the shifter produces a byte.
  always_ff @(posedge clk) begin
    if (step) begin
      out_byte   <= digit.out_byte;
      byte_count <= digit.byte_count;
      last_byte  <= digit.last_byte;
    end
  end

endmodule

### hdl/varint_unsigned_encoder.sv
// The first byte of a value passes through the shifter and then the output register before it is valid.
// Throughput: one output byte per cycle while out_ready holds; a value encodes to 1 to 9 bytes
// (9 for values of 2^56 and above); the shifter emits one group per step.
// A new value is accepted in the cycle the previous value's last byte leaves the shifter.
// Reset (rst, synchronous, active high) empties the shifter and the output register.
module varint_unsigned_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [varenc_pkg::ValueW-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [varenc_pkg::ByteW-1:0]  out_byte,
  output logic [varenc_pkg::CountW-1:0] byte_count,
  output logic                          last_byte
);
  import varenc_pkg::*;

  logic        busy;
  digit_t      digit;
  shift_ctrl_t ctrl;

  // Step when the output register is free or being emptied; load once the
  // shifter is idle or is sending its final byte.
  always_comb begin
    ctrl.step = busy && (!out_valid || out_ready);
    in_ready  = !busy || (ctrl.step && digit.last_byte);
    ctrl.load = in_valid && in_ready;
  end

  varenc_shift u_shift (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .value (value),
    .busy  (busy),
    .digit (digit)
  );

  varenc_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .step       (ctrl.step),
    .digit      (digit),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .byte_count (byte_count),
    .last_byte  (last_byte)
  );

endmodule

### hdl/varenc_checker.sv
// Port-level checks for the varint encoder, bound to the top level.
module varenc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [3:0] byte_count,
  input logic       last_byte
);

  // A stalled output word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_count)
      && $stable(last_byte))
    else $error("output word changed while stalled");

  // Byte count stays within one to nine.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count != 4'd0 && byte_count <= 4'd9)
    else $error("byte count out of range");

  // The ninth byte always ends the encoding.
  a_ninth_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 4'd9 |-> last_byte)
    else $error("ninth byte not marked last");

  // Continuation flag agrees with the last marker in the first eight bytes.
  a_cont_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count != 4'd9 |-> out_byte[7] == !last_byte)
    else $error("continuation flag mismatch");

  // After a non-final byte is taken, the next byte follows at once.
  a_next_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=>
      out_valid && byte_count == $past(byte_count) + 4'd1)
    else $error("following byte missing or miscounted");

endmodule

bind varint_unsigned_encoder varenc_checker u_varenc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .byte_count (byte_count),
  .last_byte  (last_byte)
);
